FILE: rtl/rads_pkg.sv
// Shared types and constants for the range-assign digit segment tree.
// Used by rads_ctrl and rads_dp; depends on nothing else.
package rads_pkg;

    localparam int          DIGIT_W   = 4;
    localparam int          TAG_W     = 5;
    localparam int          SUM_W     = 30;
    localparam int          CFG_W     = 11;
    localparam int          POS_W     = 11;
    localparam logic [3:0]  DIGIT_TEN = 4'd10;
    localparam logic        CMD_BUILD  = 1'b0;
    localparam logic        CMD_ASSIGN = 1'b1;

    typedef enum logic [1:0] {
        MS_WA,
        MS_WB,
        MS_PW
    } t_mul_src;

    typedef enum logic [2:0] {
        WS_MUL,
        WS_SADD,
        WS_WADD,
        WS_PW,
        WS_ZERO
    } t_wr_src;

    typedef struct packed {
        logic                 rd_en;
        logic                 mul_start;
        t_mul_src             mul_src;
        logic [DIGIT_W-1:0]   mul_digit;
        logic                 wr_sum;
        logic                 wr_wt;
        logic                 wr_tag;
        t_wr_src              wr_src;
        logic [TAG_W-1:0]     tag_val;
        logic                 pw_init;
        logic                 pw_load;
    } t_dp_cmd;

    typedef struct packed {
        logic                 mul_busy;
        logic [TAG_W-1:0]     tag;
    } t_dp_sts;

endpackage

FILE: rtl/rads_dp.sv
// Datapath of the segment tree: node sum, weight and tag memories and a
// digit-by-value modular multiplier. Depends on rads_pkg.
module rads_dp #(
    parameter int MAX_LEN = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rads_pkg::t_dp_cmd             i_cmd,
    input  logic [$clog2(MAX_LEN):0]      i_rd_addr_a,
    input  logic [$clog2(MAX_LEN):0]      i_rd_addr_b,
    input  logic [$clog2(MAX_LEN)-1:0]    i_rd_addr_t,
    input  logic [$clog2(MAX_LEN):0]      i_wr_addr,
    output rads_pkg::t_dp_sts             o_sts,
    output logic [rads_pkg::SUM_W-1:0]    o_sum_a
);
    localparam int                        LOG    = $clog2(MAX_LEN);
    localparam int                        NODES  = 2 << LOG;
    localparam int                        LEAVES = 1 << LOG;
    localparam logic [rads_pkg::SUM_W-1:0] PRIME = 30'd998244353;

    function automatic logic [rads_pkg::SUM_W-1:0] add_mod(
        input logic [rads_pkg::SUM_W-1:0] a,
        input logic [rads_pkg::SUM_W-1:0] b
    );
        logic [rads_pkg::SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, PRIME}) begin
            s = s - {1'b0, PRIME};
        end
        return s[rads_pkg::SUM_W-1:0];
    endfunction

    logic [rads_pkg::SUM_W-1:0]   r_sum_mem [NODES];
    logic [rads_pkg::SUM_W-1:0]   r_wt_mem  [NODES];
    logic [rads_pkg::TAG_W-1:0]   r_tag_mem [LEAVES];

    logic [rads_pkg::SUM_W-1:0]   r_sa, r_sb, r_wa, r_wb, r_pw;
    logic [rads_pkg::TAG_W-1:0]   r_tag;
    logic [rads_pkg::SUM_W-1:0]   r_acc, r_mw;
    logic [rads_pkg::DIGIT_W-1:0] r_md;
    logic [1:0]                   r_cnt;
    logic                         r_busy;
    logic [rads_pkg::SUM_W-1:0]   n_acc, mul_opnd, wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_sa  <= r_sum_mem[i_rd_addr_a];
            r_sb  <= r_sum_mem[i_rd_addr_b];
            r_wa  <= r_wt_mem[i_rd_addr_a];
            r_wb  <= r_wt_mem[i_rd_addr_b];
            r_tag <= r_tag_mem[i_rd_addr_t];
        end
        if (i_cmd.wr_sum) begin
            r_sum_mem[i_wr_addr] <= wdata;
        end
        if (i_cmd.wr_wt) begin
            r_wt_mem[i_wr_addr] <= wdata;
        end
        if (i_cmd.wr_tag) begin
            r_tag_mem[i_wr_addr[LOG-1:0]] <= i_cmd.tag_val;
        end
    end

    always_comb begin
        case (i_cmd.mul_src)
            rads_pkg::MS_WA: mul_opnd = r_wa;
            rads_pkg::MS_WB: mul_opnd = r_wb;
            rads_pkg::MS_PW: mul_opnd = r_pw;
            default:         mul_opnd = r_pw;
        endcase
        n_acc = add_mod(r_acc, r_acc);
        if (r_md[r_cnt]) begin
            n_acc = add_mod(n_acc, r_mw);
        end
        case (i_cmd.wr_src)
            rads_pkg::WS_MUL:  wdata = r_acc;
            rads_pkg::WS_SADD: wdata = add_mod(r_sa, r_sb);
            rads_pkg::WS_WADD: wdata = add_mod(r_wa, r_wb);
            rads_pkg::WS_PW:   wdata = r_pw;
            default:           wdata = '0;
        endcase
    end

    // Multiplier works from the top digit bit down, one bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_busy <= 1'b1;
            r_acc  <= '0;
            r_cnt  <= 2'd3;
            r_md   <= i_cmd.mul_digit;
            r_mw   <= mul_opnd;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_cnt <= r_cnt - 2'd1;
            if (r_cnt == 2'd0) begin
                r_busy <= 1'b0;
            end
        end
        if (i_cmd.pw_init) begin
            r_pw <= 30'd1;
        end else if (i_cmd.pw_load) begin
            r_pw <= r_acc;
        end
    end

    assign o_sts.mul_busy = r_busy;
    assign o_sts.tag      = r_tag;
    assign o_sum_a        = r_sa;
endmodule

FILE: rtl/rads_ctrl.sv
// Controller of the segment tree: request handshake, length register, and the
// build, push-down, cover and recombine sequences. Depends on rads_pkg.
module rads_ctrl #(
    parameter int MAX_LEN = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rads_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic                            i_cmd,
    input  logic [rads_pkg::POS_W-1:0]      i_left,
    input  logic [rads_pkg::POS_W-1:0]      i_right,
    input  logic [rads_pkg::DIGIT_W-1:0]    i_digit,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rads_pkg::SUM_W-1:0]      o_total,
    output logic                            o_err,
    output rads_pkg::t_dp_cmd               o_dp_cmd,
    output logic [$clog2(MAX_LEN):0]        o_rd_addr_a,
    output logic [$clog2(MAX_LEN):0]        o_rd_addr_b,
    output logic [$clog2(MAX_LEN)-1:0]      o_rd_addr_t,
    output logic [$clog2(MAX_LEN):0]        o_wr_addr,
    input  rads_pkg::t_dp_sts               i_dp_sts,
    input  logic [rads_pkg::SUM_W-1:0]      i_sum_a
);
    localparam int LOG    = $clog2(MAX_LEN);
    localparam int NA     = LOG + 1;
    localparam int NB     = LOG + 2;
    localparam int LVW    = $clog2(LOG + 1);
    localparam int LEAVES = 1 << LOG;

    typedef enum logic [4:0] {
        S_IDLE, S_BL, S_BLM, S_BNR, S_BNW,
        S_PSEL, S_PRD, S_PCHK, S_PM0, S_PM1, S_PCLR, S_PNXT,
        S_CSEL, S_CSB, S_CSH, S_SRD, S_SM, S_SMW,
        S_RSEL, S_RRD, S_RW, S_RNXT,
        S_ROOT, S_OUT
    } t_state;

    t_state                          r_state;
    logic [rads_pkg::CFG_W-1:0]      r_cfg_len;
    logic [NA-1:0]                   r_len, r_j, r_k;
    logic [NB-1:0]                   r_l, r_r, r_a, r_b;
    logic [LVW-1:0]                  r_lvl;
    logic                            r_side, r_err, r_built, r_ovalid, r_oerr;
    logic [rads_pkg::DIGIT_W-1:0]    r_d;
    logic [rads_pkg::SUM_W-1:0]      r_total;

    logic [31:0]     cur_len;
    logic            accept, bad_range, sel_need, leaf_used, child_int;
    logic [NB-1:0]   sel_x, sel_m, sel_mask;
    logic [NA-1:0]   sel_node, k2;

    always_comb begin
        if (r_cfg_len == '0) begin
            cur_len = 32'd1;
        end else if (32'(r_cfg_len) > 32'(MAX_LEN)) begin
            cur_len = 32'(MAX_LEN);
        end else begin
            cur_len = 32'(r_cfg_len);
        end
        accept    = i_s_tvalid && (r_state == S_IDLE);
        bad_range = (i_left == '0) || (i_left > i_right) || (32'(i_right) > cur_len);
        sel_x     = r_side ? (r_r - NB'(1)) : r_l;
        sel_m     = r_side ? r_r : r_l;
        sel_mask  = (NB'(1) << r_lvl) - NB'(1);
        sel_need  = (sel_m & sel_mask) != '0;
        sel_node  = NA'(sel_x >> r_lvl);
        leaf_used = 32'(r_j[LOG-1:0]) < 32'(r_len);
        k2        = {r_k[NA-2:0], 1'b0};
        child_int = !r_k[LOG-1];
    end

    always_comb begin
        o_dp_cmd    = '0;
        o_rd_addr_a = k2;
        o_rd_addr_b = k2 | NA'(1);
        o_rd_addr_t = r_k[LOG-1:0];
        o_wr_addr   = r_k;
        case (r_state)
            S_IDLE: begin
                o_dp_cmd.pw_init = accept && (i_cmd == rads_pkg::CMD_BUILD);
            end
            S_BL: begin
                o_wr_addr          = r_j;
                o_dp_cmd.wr_sum    = 1'b1;
                o_dp_cmd.wr_wt     = 1'b1;
                o_dp_cmd.wr_src    = leaf_used ? rads_pkg::WS_PW : rads_pkg::WS_ZERO;
                o_dp_cmd.mul_start = leaf_used;
                o_dp_cmd.mul_src   = rads_pkg::MS_PW;
                o_dp_cmd.mul_digit = rads_pkg::DIGIT_TEN;
            end
            S_BLM: begin
                o_dp_cmd.pw_load = !i_dp_sts.mul_busy;
            end
            S_BNR: begin
                o_rd_addr_a     = {r_j[NA-2:0], 1'b0};
                o_rd_addr_b     = {r_j[NA-2:0], 1'b1};
                o_dp_cmd.rd_en  = 1'b1;
            end
            S_BNW: begin
                o_wr_addr       = r_j;
                o_dp_cmd.wr_sum = 1'b1;
                o_dp_cmd.wr_wt  = 1'b1;
                o_dp_cmd.wr_tag = 1'b1;
                o_dp_cmd.wr_src = rads_pkg::WS_WADD;
            end
            S_PRD, S_RRD: begin
                o_dp_cmd.rd_en = 1'b1;
            end
            S_PCHK: begin
                o_dp_cmd.mul_start = i_dp_sts.tag[rads_pkg::TAG_W-1];
                o_dp_cmd.mul_src   = rads_pkg::MS_WA;
                o_dp_cmd.mul_digit = i_dp_sts.tag[rads_pkg::DIGIT_W-1:0];
            end
            S_PM0, S_PM1: begin
                o_wr_addr          = (r_state == S_PM0) ? k2 : (k2 | NA'(1));
                o_dp_cmd.wr_sum    = !i_dp_sts.mul_busy;
                o_dp_cmd.wr_tag    = !i_dp_sts.mul_busy && child_int;
                o_dp_cmd.wr_src    = rads_pkg::WS_MUL;
                o_dp_cmd.tag_val   = i_dp_sts.tag;
                o_dp_cmd.mul_start = (r_state == S_PM0) && !i_dp_sts.mul_busy;
                o_dp_cmd.mul_src   = rads_pkg::MS_WB;
                o_dp_cmd.mul_digit = i_dp_sts.tag[rads_pkg::DIGIT_W-1:0];
            end
            S_PCLR: begin
                o_dp_cmd.wr_tag = 1'b1;
            end
            S_SRD: begin
                o_rd_addr_a    = r_k;
                o_dp_cmd.rd_en = 1'b1;
            end
            S_SM: begin
                o_dp_cmd.mul_start = 1'b1;
                o_dp_cmd.mul_src   = rads_pkg::MS_WA;
                o_dp_cmd.mul_digit = r_d;
            end
            S_SMW: begin
                o_dp_cmd.wr_sum  = !i_dp_sts.mul_busy;
                o_dp_cmd.wr_tag  = !i_dp_sts.mul_busy && !r_k[NA-1];
                o_dp_cmd.wr_src  = rads_pkg::WS_MUL;
                o_dp_cmd.tag_val = {1'b1, r_d};
            end
            S_RW: begin
                o_dp_cmd.wr_sum = 1'b1;
                o_dp_cmd.wr_src = rads_pkg::WS_SADD;
            end
            S_ROOT: begin
                o_rd_addr_a    = NA'(1);
                o_dp_cmd.rd_en = 1'b1;
            end
            default: begin
                o_dp_cmd.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cfg_len <= rads_pkg::CFG_W'(1);
            r_built   <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_len <= i_cfg_wdata;
            end
            if (r_ovalid && i_m_tready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_d    <= i_digit;
                        r_lvl  <= LVW'(LOG);
                        r_side <= 1'b0;
                        r_l    <= NB'(32'(i_left) - 32'd1 + 32'(LEAVES));
                        r_r    <= NB'(32'(i_right) + 32'(LEAVES));
                        if (i_cmd == rads_pkg::CMD_BUILD) begin
                            r_err   <= 1'b0;
                            r_len   <= NA'(cur_len);
                            r_j     <= '1;
                            r_state <= S_BL;
                        end else begin
                            r_err   <= bad_range;
                            r_state <= (bad_range || !r_built) ? S_ROOT : S_PSEL;
                        end
                    end
                end
                S_BL, S_BLM: begin
                    if (r_state == S_BL && leaf_used) begin
                        r_state <= S_BLM;
                    end else if (!i_dp_sts.mul_busy) begin
                        if (r_j == NA'(LEAVES)) begin
                            r_j     <= NA'(LEAVES - 1);
                            r_state <= S_BNR;
                        end else begin
                            r_j     <= r_j - NA'(1);
                            r_state <= S_BL;
                        end
                    end
                end
                S_BNR: r_state <= S_BNW;
                S_BNW: begin
                    if (r_j == NA'(1)) begin
                        r_built <= 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_j     <= r_j - NA'(1);
                        r_state <= S_BNR;
                    end
                end
                S_PSEL: begin
                    r_k     <= sel_node;
                    r_state <= sel_need ? S_PRD : S_PNXT;
                end
                S_PRD:  r_state <= S_PCHK;
                S_PCHK: r_state <= i_dp_sts.tag[rads_pkg::TAG_W-1] ? S_PM0 : S_PNXT;
                S_PM0:  if (!i_dp_sts.mul_busy) r_state <= S_PM1;
                S_PM1:  if (!i_dp_sts.mul_busy) r_state <= S_PCLR;
                S_PCLR: r_state <= S_PNXT;
                S_PNXT: begin
                    r_side <= !r_side;
                    if (!r_side) begin
                        r_state <= S_PSEL;
                    end else if (r_lvl == LVW'(1)) begin
                        r_a     <= r_l;
                        r_b     <= r_r;
                        r_state <= S_CSEL;
                    end else begin
                        r_lvl   <= r_lvl - LVW'(1);
                        r_state <= S_PSEL;
                    end
                end
                S_CSEL: begin
                    if (r_a >= r_b) begin
                        r_lvl   <= LVW'(1);
                        r_side  <= 1'b0;
                        r_state <= S_RSEL;
                    end else if (r_a[0]) begin
                        r_k     <= NA'(r_a);
                        r_a     <= r_a + NB'(1);
                        r_side  <= 1'b0;
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_CSB;
                    end
                end
                S_CSB: begin
                    if (r_b[0]) begin
                        r_k     <= NA'(r_b - NB'(1));
                        r_b     <= r_b - NB'(1);
                        r_side  <= 1'b1;
                        r_state <= S_SRD;
                    end else begin
                        r_state <= S_CSH;
                    end
                end
                S_CSH: begin
                    r_a     <= r_a >> 1;
                    r_b     <= r_b >> 1;
                    r_state <= S_CSEL;
                end
                S_SRD: r_state <= S_SM;
                S_SM:  r_state <= S_SMW;
                S_SMW: if (!i_dp_sts.mul_busy) r_state <= r_side ? S_CSH : S_CSB;
                S_RSEL: begin
                    r_k     <= sel_node;
                    r_state <= sel_need ? S_RRD : S_RNXT;
                end
                S_RRD: r_state <= S_RW;
                S_RW:  r_state <= S_RNXT;
                S_RNXT: begin
                    r_side <= !r_side;
                    if (!r_side) begin
                        r_state <= S_RSEL;
                    end else if (r_lvl == LVW'(LOG)) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_lvl   <= r_lvl + LVW'(1);
                        r_state <= S_RSEL;
                    end
                end
                S_ROOT: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid <= 1'b1;
                        r_total  <= r_built ? i_sum_a : '0;
                        r_oerr   <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_total    = r_total;
    assign o_err      = r_oerr;
endmodule

FILE: rtl/range_assign_digit_segment_tree_core.sv
// Top level of the range-assign digit segment tree.
// Joins rads_ctrl and rads_dp; depends on rads_pkg.
//
// A request on the slave stream either rebuilds the string as all ones
// (tuser 0) or assigns one digit to a 1-based range (tuser 1). Every request
// gives one result on the master stream: the string value modulo 998244353
// in tdata and a range error flag in tuser. The length register is written
// through i_cfg_we / i_cfg_wdata; the user must write it only while the block
// is idle, which the block itself does not enforce. One request is worked at
// a time. An assign walks the tree level by level with one shared digit
// multiplier. A bad range or an assign before the first rebuild skips the
// tree walk and goes straight to the result. A rebuild writes every leaf,
// multiplying the weight by ten once per used position, and then every
// internal node. The next request is taken while a result still waits; a
// stalled receiver holds the block only once the next result is ready.
// After reset the length is 1, no rebuild has happened and the total reads
// as zero; the node memories need no clearing pass.
module range_assign_digit_segment_tree_core #(
    parameter int MAX_LEN = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,   // length_in_use
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,     // left_pos[10:0], right_pos[21:11], digit[25:22]
    input  logic        i_s_tuser,     // cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,     // total_mod[29:0]
    output logic        o_m_tuser      // range_error
);
    localparam int LOG = $clog2(MAX_LEN);

    rads_pkg::t_dp_cmd              dp_cmd;
    rads_pkg::t_dp_sts              dp_sts;
    logic [LOG:0]                   rd_addr_a, rd_addr_b, wr_addr;
    logic [LOG-1:0]                 rd_addr_t;
    logic [rads_pkg::SUM_W-1:0]     sum_a, total;

    rads_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cmd       (i_s_tuser),
        .i_left      (i_s_tdata[10:0]),
        .i_right     (i_s_tdata[21:11]),
        .i_digit     (i_s_tdata[25:22]),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_total     (total),
        .o_err       (o_m_tuser),
        .o_dp_cmd    (dp_cmd),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_rd_addr_t (rd_addr_t),
        .o_wr_addr   (wr_addr),
        .i_dp_sts    (dp_sts),
        .i_sum_a     (sum_a)
    );

    rads_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_rd_addr_t (rd_addr_t),
        .i_wr_addr   (wr_addr),
        .o_sts       (dp_sts),
        .o_sum_a     (sum_a)
    );

    assign o_m_tdata = {2'b00, total};
endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for range_assign_digit_segment_tree_core with a lazy tree
// predictor of the digit string value modulo 998244353; depends on the core and rads_pkg.
module tb;

    localparam int LEAVES = 1024;
    localparam int LEVELS = 10;
    localparam longint PRIME = 64'd998244353;
    localparam int LIMIT = 6000000;

    typedef struct {
        bit                         cmd;
        logic [rads_pkg::POS_W-1:0] left_pos;
        logic [rads_pkg::POS_W-1:0] right_pos;
        logic [3:0]                 digit;
    } t_request;

    typedef struct {
        logic [rads_pkg::SUM_W-1:0] total;
        bit                         range_err;
    } t_answer;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [10:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_data;
    logic        m_user;

    t_request pending[$];
    t_answer  answers_due[$];
    int       cycle = 0;
    int       errors = 0;
    int       burst_left = 4;
    int       gap_left = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    bit       choppy = 1'b0;

    longint                     sum_mem[2*LEAVES];
    longint                     wt_mem[2*LEAVES];
    logic [rads_pkg::TAG_W-1:0] tag_mem[LEAVES];
    int                         len_reg = 1;

    range_assign_digit_segment_tree_core u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .i_s_tuser(s_user), .o_m_tvalid(m_valid), .i_m_tready(m_ready),
        .o_m_tdata(m_data), .o_m_tuser(m_user)
    );

    always #10 clk = ~clk;

    function automatic int used_len();
        if (len_reg == 0) return 1;
        if (len_reg > LEAVES) return LEAVES;
        return len_reg;
    endfunction

    function automatic void paint_node(int k, int d);
        sum_mem[k] = (d * wt_mem[k]) % PRIME;
        if (k < LEAVES) tag_mem[k] = {1'b1, 4'(d)};
    endfunction

    function automatic void push_paint(int k);
        if (tag_mem[k][4] !== 1'b1) return;
        paint_node(2 * k, int'(tag_mem[k][3:0]));
        paint_node(2 * k + 1, int'(tag_mem[k][3:0]));
        tag_mem[k] = '0;
    endfunction

    function automatic void rebuild_ones();
        longint pw;
        int     n;
        n = used_len();
        pw = 1;
        for (int i = 0; i < 2 * LEAVES; i++) wt_mem[i] = 0;
        for (int i = 0; i < LEAVES; i++) tag_mem[i] = '0;
        for (int i = n; i > 0; i--) begin
            wt_mem[LEAVES + i - 1] = pw;
            pw = (pw * 10) % PRIME;
        end
        for (int i = LEAVES - 1; i >= 1; i--)
            wt_mem[i] = (wt_mem[2 * i] + wt_mem[2 * i + 1]) % PRIME;
        for (int i = 1; i < 2 * LEAVES; i++) sum_mem[i] = wt_mem[i];
    endfunction

    function automatic void paint_range(int lo, int hi, int d);
        int l;
        int r;
        int a;
        int b;
        l = lo + LEAVES;
        r = hi + LEAVES;
        for (int i = LEVELS; i >= 1; i--) begin
            if (((l >> i) << i) != l) push_paint(l >> i);
            if (((r >> i) << i) != r) push_paint((r - 1) >> i);
        end
        a = l;
        b = r;
        while (a < b) begin
            if (a & 1) begin
                paint_node(a, d);
                a++;
            end
            if (b & 1) begin
                b--;
                paint_node(b, d);
            end
            a = a >> 1;
            b = b >> 1;
        end
        for (int i = 1; i <= LEVELS; i++) begin
            if (((l >> i) << i) != l)
                sum_mem[l >> i] = (sum_mem[2 * (l >> i)] + sum_mem[2 * (l >> i) + 1]) % PRIME;
            if (((r >> i) << i) != r)
                sum_mem[(r - 1) >> i] =
                    (sum_mem[2 * ((r - 1) >> i)] + sum_mem[2 * ((r - 1) >> i) + 1]) % PRIME;
        end
    endfunction

    function automatic t_answer predict_total(t_request q);
        t_answer ans;
        ans.range_err = 1'b0;
        if (q.cmd == rads_pkg::CMD_BUILD) begin
            rebuild_ones();
        end else if (q.left_pos == 0 || q.left_pos > q.right_pos || q.right_pos > used_len()) begin
            ans.range_err = 1'b1;
        end else begin
            paint_range(int'(q.left_pos) - 1, int'(q.right_pos), int'(q.digit));
        end
        ans.total = sum_mem[1][rads_pkg::SUM_W-1:0];
        return ans;
    endfunction

    always @(posedge clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Sender: bursts of requests separated by random gaps.
    always @(posedge clk) begin
        t_request q;
        if (s_valid && s_ready) begin
            q.cmd = s_user;
            q.left_pos = s_data[10:0];
            q.right_pos = s_data[21:11];
            q.digit = s_data[25:22];
            answers_due.push_back(predict_total(q));
        end
        if (rst_n && (!s_valid || s_ready)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending.size() > 0) begin
                q = pending.pop_front();
                s_valid <= 1'b1;
                s_user <= q.cmd;
                s_data <= {6'd0, q.digit, q.right_pos, q.left_pos};
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: choppy or steady ready, plus one long hold-off.
    always @(posedge clk) begin
        t_answer want;
        if (m_valid && m_ready) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result total=%0d err=%0d", $time, m_data, m_user);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (m_data !== {2'b00, want.total} || m_user !== want.range_err) begin
                    $display("%0t: expected total=%0d err=%0d, got total=%0d err=%0d",
                             $time, want.total, want.range_err, m_data, m_user);
                    errors++;
                end
            end
        end
        if (!hold_done && cycle >= 40000 && pending.size() > 10) begin
            hold_left <= 4000;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
        if ($urandom_range(0, 199) == 0) choppy <= ~choppy;
        if (!rst_n || hold_left > 0) m_ready <= 1'b0;
        else m_ready <= choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    task automatic add_req(bit c, int lp, int rp, int d);
        t_request q;
        q.cmd = c;
        q.left_pos = rads_pkg::POS_W'(lp);
        q.right_pos = rads_pkg::POS_W'(rp);
        q.digit = 4'(d);
        pending.push_back(q);
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || s_valid || answers_due.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_length(int v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 11'(v);
        len_reg = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_random(int count);
        int n;
        int a;
        int b;
        int pick;
        n = used_len();
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
            if (a > b) begin
                a = a + b;
                b = a - b;
                a = a - b;
            end
            if (pick < 4 && n <= 64)
                add_req(rads_pkg::CMD_BUILD, $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 15));
            else if (pick < 14)
                add_req(rads_pkg::CMD_ASSIGN, $urandom_range(0, 2047), $urandom_range(0, 2047),
                        $urandom_range(0, 15));
            else if (pick < 20)
                add_req(rads_pkg::CMD_ASSIGN, a, b, $urandom_range(0, 15));
            else if (pick < 30)
                add_req(rads_pkg::CMD_ASSIGN, a, a, $urandom_range(0, 9));
            else
                add_req(rads_pkg::CMD_ASSIGN, a, b, $urandom_range(0, 9));
        end
    endtask

    initial begin
        int lens[10];
        lens = '{0, 1024, 2047, 5, 2, 37, 300, 64, 13, 1000};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Assign before any rebuild, then length one extremes.
        add_req(rads_pkg::CMD_ASSIGN, 1, 1, 7);
        add_req(rads_pkg::CMD_BUILD, 2047, 2047, 15);
        add_req(rads_pkg::CMD_ASSIGN, 1, 1, 9);
        add_req(rads_pkg::CMD_ASSIGN, 0, 1, 3);
        add_req(rads_pkg::CMD_ASSIGN, 1, 2, 3);
        add_req(rads_pkg::CMD_ASSIGN, 1, 1, 15);
        wait_idle();
        set_length(7);
        add_req(rads_pkg::CMD_BUILD, 0, 0, 0);
        add_req(rads_pkg::CMD_ASSIGN, 2, 5, 9);
        add_req(rads_pkg::CMD_ASSIGN, 3, 3, 0);
        add_req(rads_pkg::CMD_ASSIGN, 1, 7, 4);
        add_req(rads_pkg::CMD_ASSIGN, 6, 7, 12);
        add_req(rads_pkg::CMD_ASSIGN, 5, 4, 1);
        add_req(rads_pkg::CMD_ASSIGN, 7, 8, 1);
        add_req(rads_pkg::CMD_ASSIGN, 1024, 2047, 2);
        wait_idle();
        // Shorter length without a rebuild keeps the old weights.
        set_length(3);
        add_req(rads_pkg::CMD_ASSIGN, 1, 3, 8);
        add_req(rads_pkg::CMD_ASSIGN, 2, 4, 8);
        wait_idle();
        set_length(1024);
        add_req(rads_pkg::CMD_BUILD, 0, 0, 0);
        add_req(rads_pkg::CMD_ASSIGN, 1, 1024, 9);
        add_req(rads_pkg::CMD_ASSIGN, 512, 513, 0);
        add_req(rads_pkg::CMD_ASSIGN, 1024, 1024, 3);
        add_req(rads_pkg::CMD_ASSIGN, 1, 1025, 3);
        wait_idle();

        foreach (lens[i]) begin
            set_length(lens[i]);
            if (lens[i] <= 64 || $urandom_range(0, 1) == 0) add_req(rads_pkg::CMD_BUILD, 0, 0, 0);
            add_random(100);
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
